@@ hw/rtl/cascaded_block_average_decimator_macros.svh @@
// Assertion macros shared by the decimator RTL.
// Each macro expects clk and rst_n in scope.
`ifndef CASCADED_BLOCK_AVERAGE_DECIMATOR_MACROS_SVH
`define CASCADED_BLOCK_AVERAGE_DECIMATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBAD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cbad_pkg.sv @@
`timescale 1ns / 1ps

package cbad_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int TAG_BITS      = 8;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 8;
    localparam int STAGE_COUNT_W = 3;
    localparam int BLOCK_SIZE_W  = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_STAGE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;

    localparam logic [STAGE_COUNT_W-1:0] STAGE_COUNT_RESET = 3'd1;
    localparam logic [BLOCK_SIZE_W-1:0]  BLOCK_SIZE_RESET  = 5'd4;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [TAG_BITS-1:0]    variable_index;
    } item_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] average;
        logic [TAG_BITS-1:0]    variable_tag;
    } result_t;

    // Status of a bit-serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } ser_status_t;

endpackage

@@ hw/rtl/cbad_serial_adder.sv @@
`timescale 1ns / 1ps

// Bit-serial adder: operands shift out LSB first, one bit per cycle, and the
// sum shifts in from the top. The result is valid from the done pulse on.
module cbad_serial_adder
    import cbad_pkg::*;
#(
    parameter int WIDTH = 20
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output ser_status_t      status,
    output logic [WIDTH-1:0] sum
);

    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] sum_reg;
    logic             carry_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             sum_bit;
    logic             carry_next;

    assign sum_bit    = a_reg[0] ^ b_reg[0] ^ carry_reg;
    assign carry_next = (a_reg[0] & b_reg[0]) | (carry_reg & (a_reg[0] ^ b_reg[0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            carry_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                carry_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                carry_reg <= carry_next;
                cnt_reg   <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            a_reg   <= {1'b0, a_reg[WIDTH-1:1]};
            b_reg   <= {1'b0, b_reg[WIDTH-1:1]};
            sum_reg <= {sum_bit, sum_reg[WIDTH-1:1]};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign sum         = sum_reg;

endmodule

@@ hw/rtl/cbad_serial_divider.sv @@
`timescale 1ns / 1ps

// Restoring divider that produces one quotient bit per cycle, MSB first.
// The quotient shifts into the dividend register as the dividend shifts out.
module cbad_serial_divider
    import cbad_pkg::*;
#(
    parameter int WIDTH = 20,
    parameter int DIV_W = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output ser_status_t      status,
    output logic [WIDTH-1:0] quotient
);

    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0] dvd_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W:0]   rem_shift;
    logic [DIV_W:0]   diff;
    logic             q_bit;

    assign rem_shift = {rem_reg, dvd_reg[WIDTH-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};
    assign q_bit     = ~diff[DIV_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[WIDTH-2:0], q_bit};
            rem_reg <= q_bit ? diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = dvd_reg;

endmodule

@@ hw/rtl/cascaded_block_average_decimator.sv @@
// Throughput: one item at a time; a new item is taken only once the bit-serial adder, the
// divider and the output are through with the last. SUM_W = 16 + clog2(MAX_BLOCK), 20 by default.
// Reset: asynchronous, active low; clears all stage sums and positions, the latest
// average and the output valid, and restores stage_count = 1 and block_size = 4.
`timescale 1ns / 1ps

`include "cascaded_block_average_decimator_macros.svh"

module cascaded_block_average_decimator
    import cbad_pkg::*;
#(
    parameter int MAX_STAGES = 4,
    parameter int MAX_BLOCK  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Widths that follow from the parameters. A stored position never exceeds
    // MAX_BLOCK - 1, and a stage sum never covers more than MAX_BLOCK samples.
    localparam int POS_W   = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_BLOCK);
    localparam int STAGE_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int NSTG_W  = $clog2(MAX_STAGES + 1);

    // Sequencer states.
    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
    localparam logic [STATE_W-1:0] ST_LOAD = 3'd1;
    localparam logic [STATE_W-1:0] ST_ADD  = 3'd2;
    localparam logic [STATE_W-1:0] ST_DIV  = 3'd3;
    localparam logic [STATE_W-1:0] ST_OUT  = 3'd4;

    logic [STATE_W-1:0]       state_reg;
    logic [STAGE_W-1:0]       stage_reg;
    logic [SAMPLE_BITS-1:0]   value_reg;
    logic [TAG_BITS-1:0]      tag_reg;

    logic [STAGE_COUNT_W-1:0] stage_count_reg;
    logic [BLOCK_SIZE_W-1:0]  block_size_reg;

    logic [SUM_W-1:0]         stage_sum_reg [MAX_STAGES];
    logic [POS_W-1:0]         stage_pos_reg [MAX_STAGES];

    logic [SAMPLE_BITS-1:0]   latest_average_reg;
    logic [TAG_BITS-1:0]      result_tag_reg;
    logic                     result_valid_reg;

    logic [NSTG_W-1:0]        used_stages;
    logic [POS_W-1:0]         used_block;
    logic [POS_W-1:0]         pos_inc;
    logic                     block_full;
    logic                     stage_last;
    logic                     item_xfer;
    logic                     out_free;

    logic                     add_start;
    logic [SUM_W-1:0]         add_sum;
    ser_status_t              add_status;
    logic                     div_start;
    logic [SUM_W-1:0]         div_quotient;
    ser_status_t              div_status;
    logic [SAMPLE_BITS-1:0]   quotient_sat;

    // ------------------------------------------------------------------
    // Configuration port. Writes are always taken; an index that names no
    // register is ignored. Only the low bits of the data are kept.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_count_reg <= STAGE_COUNT_RESET;
            block_size_reg  <= BLOCK_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STAGE_COUNT: stage_count_reg <= cfg_data[STAGE_COUNT_W-1:0];
                CFG_BLOCK_SIZE:  block_size_reg  <= cfg_data[BLOCK_SIZE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Effective stage count and block size: zero means one, and values above
    // the built-in maximum saturate to it.
    always_comb
    begin
        if (stage_count_reg == '0)
            used_stages = NSTG_W'(1);
        else if (int'(stage_count_reg) > MAX_STAGES)
            used_stages = NSTG_W'(MAX_STAGES);
        else
            used_stages = NSTG_W'(stage_count_reg);

        if (block_size_reg == '0)
            used_block = POS_W'(1);
        else if (int'(block_size_reg) > MAX_BLOCK)
            used_block = POS_W'(MAX_BLOCK);
        else
            used_block = POS_W'(block_size_reg);
    end

    // ------------------------------------------------------------------
    // Datapath. The current stage's running sum and the value entering it
    // go through the serial adder. If the stage's block is then full, the
    // new sum goes through the serial divider and the quotient becomes the
    // value for the next stage. A lowered block size can leave more samples
    // in a sum than the divisor, so the quotient saturates to the sample range.
    // ------------------------------------------------------------------
    assign pos_inc    = stage_pos_reg[stage_reg] + POS_W'(1);
    assign block_full = (pos_inc >= used_block);
    assign stage_last = ((NSTG_W'(stage_reg) + NSTG_W'(1)) == used_stages);

    assign add_start = (state_reg == ST_LOAD);
    assign div_start = (state_reg == ST_ADD) && add_status.done && block_full;

    assign quotient_sat = (div_quotient > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                              : SAMPLE_BITS'(div_quotient);

    cbad_serial_adder #(
        .WIDTH (SUM_W)
    ) u_adder (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (add_start),
        .a      (stage_sum_reg[stage_reg]),
        .b      (SUM_W'(value_reg)),
        .status (add_status),
        .sum    (add_sum)
    );

    cbad_serial_divider #(
        .WIDTH (SUM_W),
        .DIV_W (POS_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (add_sum),
        .divisor  (used_block),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // ------------------------------------------------------------------
    // Handshakes. A new input transfer is taken only while the sequencer is
    // idle. The output register frees the sequencer from the output side: a
    // finished result may wait there while the next item is processed.
    // ------------------------------------------------------------------
    assign item_stall = (state_reg != ST_IDLE);
    assign item_xfer  = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;

    // ------------------------------------------------------------------
    // Sequencer and stage state.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            stage_reg          <= '0;
            latest_average_reg <= '0;
            result_valid_reg   <= 1'b0;
            for (int k = 0; k < MAX_STAGES; k++)
            begin
                stage_sum_reg[k] <= '0;
                stage_pos_reg[k] <= '0;
            end
        end
        else
        begin
            if (!result_stall)
                result_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_xfer)
                    begin
                        stage_reg <= '0;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    if (add_status.done)
                    begin
                        if (block_full)
                        begin
                            stage_sum_reg[stage_reg] <= '0;
                            stage_pos_reg[stage_reg] <= '0;
                            state_reg                <= ST_DIV;
                        end
                        else
                        begin
                            stage_sum_reg[stage_reg] <= add_sum;
                            stage_pos_reg[stage_reg] <= pos_inc;
                            state_reg                <= ST_IDLE;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_status.done)
                    begin
                        if (stage_last)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            stage_reg <= stage_reg + STAGE_W'(1);
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        latest_average_reg <= value_reg;
                        result_valid_reg   <= 1'b1;
                        state_reg          <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers: the value moving down the cascade, its tag, and the
    // tag of the result held at the output.
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            value_reg <= item.sample;
            tag_reg   <= item.variable_index;
        end
        else if ((state_reg == ST_DIV) && div_status.done)
        begin
            value_reg <= quotient_sat;
        end

        if ((state_reg == ST_OUT) && out_free)
            result_tag_reg <= tag_reg;
    end

    assign result_valid        = result_valid_reg;
    assign result.average      = latest_average_reg;
    assign result.variable_tag = result_tag_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `CBAD_ASSERT_SAME(a_units_exclusive, add_status.busy, !div_status.busy,
        "adder and divider busy at the same time")
    `CBAD_ASSERT_NEXT(a_accept_starts_load, item_xfer, state_reg == ST_LOAD,
        "accepted item did not start the cascade")
    `CBAD_ASSERT_SAME(a_out_only_after_last, state_reg == ST_OUT, stage_last,
        "result raised before the last stage in use")
    `CBAD_ASSERT_SAME(a_div_only_on_full, div_start, add_status.done && block_full,
        "division started for a stage whose block is not full")

endmodule
